// ===== sv/orb_pkg.sv =====
// Shared constants and controller/datapath interface types for the overwriting ring buffer.
package orb_pkg;

    localparam int unsigned DEPTH_DEFAULT      = 16;
    localparam int unsigned DATA_WIDTH_DEFAULT = 32;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DIN_W   = 32;
    localparam int unsigned DOUT_W  = 32;
    localparam int unsigned FILL_W  = 5;
    localparam int unsigned OTDATA_W = 40;
    localparam int unsigned OTUSER_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;        // write the input word and advance count or head
        logic load_imm;    // load a result that carries no stored word
        logic load_entry;  // load a result from the read data register
        logic entry_last;  // last flag for a loaded entry
        logic pop_adv;     // retire the oldest entry
        logic idx_inc;     // step the stream index
        logic idx_clr;     // hold the stream index at the oldest entry
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic idx_last;
    } t_dp_sts;

endpackage

// ===== sv/orb_dp.sv =====
// Datapath of the overwriting ring buffer: entry memory, pointers and result register.
module orb_dp #(
    parameter int unsigned DEPTH      = orb_pkg::DEPTH_DEFAULT,
    parameter int unsigned DATA_WIDTH = orb_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  orb_pkg::t_dp_cmd            i_cmd,
    output orb_pkg::t_dp_sts            o_sts,
    input  logic [orb_pkg::DIN_W-1:0]   i_data_in,
    output logic [orb_pkg::DOUT_W-1:0]  o_data_out,
    output logic                        o_valid_res,
    output logic                        o_last,
    output logic                        o_overwrote,
    output logic [orb_pkg::FILL_W-1:0]  o_fill_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = orb_pkg::DIN_W;
    localparam int unsigned OW = orb_pkg::DOUT_W;
    localparam int unsigned FW = orb_pkg::FILL_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;

    logic [DATA_WIDTH-1:0] r_dout;
    logic                  r_valid_res;
    logic                  r_last;
    logic                  r_ovw;
    logic [CW-1:0]         r_fill;

    logic [DATA_WIDTH-1:0] w_din;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic                  w_full;
    logic                  w_empty;
    logic [AW-1:0]         w_head_inc;

    // Sum of two positions below twice the depth, folded back into range.
    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] s);
        logic [CW:0] t;
        begin
            t = (s >= (CW+1)'(DEPTH)) ? s - (CW+1)'(DEPTH) : s;
            return t[AW-1:0];
        end
    endfunction

    generate
        if (DATA_WIDTH <= IW) begin : g_din_trunc
            assign w_din = i_data_in[DATA_WIDTH-1:0];
        end else begin : g_din_ext
            assign w_din = {{(DATA_WIDTH-IW){1'b0}}, i_data_in};
        end
        if (DATA_WIDTH >= OW) begin : g_dout_trunc
            assign o_data_out = r_dout[OW-1:0];
        end else begin : g_dout_ext
            assign o_data_out = {{(OW-DATA_WIDTH){1'b0}}, r_dout};
        end
        if (CW >= FW) begin : g_fill_trunc
            assign o_fill_count = r_fill[FW-1:0];
        end else begin : g_fill_ext
            assign o_fill_count = {{(FW-CW){1'b0}}, r_fill};
        end
    endgenerate

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_waddr    = f_wrap((CW+1)'(r_head) + (CW+1)'(r_count));

    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    // The memory is read every cycle at the next stream position, so the read
    // data register holds the entry the stream index points at when a stream load uses it.
    assign w_raddr = f_wrap((CW+1)'(r_head) + (CW+1)'(n_idx));

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            if (w_full) begin
                n_head = w_head_inc;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_cmd.pop_adv) begin
            n_head  = w_head_inc;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_waddr] <= w_din;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_imm) begin
            r_dout      <= '0;
            r_valid_res <= 1'b0;
            r_last      <= 1'b1;
            r_ovw       <= i_cmd.push & w_full;
            r_fill      <= n_count;
        end else if (i_cmd.load_entry) begin
            r_dout      <= r_rdata;
            r_valid_res <= 1'b1;
            r_last      <= i_cmd.entry_last;
            r_ovw       <= 1'b0;
            r_fill      <= n_count;
        end
    end

    assign o_valid_res = r_valid_res;
    assign o_last      = r_last;
    assign o_overwrote = r_ovw;

    assign o_sts.empty    = w_empty;
    assign o_sts.idx_last = ((CW'(r_idx) + 1'b1) == r_count);

endmodule

// ===== sv/orb_ctrl.sv =====
// Controller of the overwriting ring buffer: operation decode, streaming sequence, output handshake.
module orb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [orb_pkg::MODE_W-1:0]   i_mode,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  orb_pkg::t_dp_sts             i_sts,
    output orb_pkg::t_dp_cmd             o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic r_state, n_state;
    logic r_is_pop, n_is_pop;
    logic r_out_valid, n_out_valid;
    logic w_out_free;
    logic w_accept;
    logic w_last;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_last     = r_is_pop || i_sts.idx_last;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_is_pop = r_is_pop;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.idx_clr = 1'b1;
                if (w_accept) begin
                    unique case (i_mode) inside
                        orb_pkg::MODE_PUSH: begin
                            o_cmd.push     = 1'b1;
                            o_cmd.load_imm = 1'b1;
                        end
                        orb_pkg::MODE_POP, orb_pkg::MODE_DUMP: begin
                            if (i_sts.empty) begin
                                o_cmd.load_imm = 1'b1;
                            end else begin
                                n_state  = ST_STREAM;
                                n_is_pop = (i_mode == orb_pkg::MODE_POP);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STREAM: begin
                if (w_out_free) begin
                    o_cmd.load_entry = 1'b1;
                    o_cmd.entry_last = w_last;
                    o_cmd.pop_adv    = r_is_pop;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_imm || o_cmd.load_entry) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_pop    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_pop    <= n_is_pop;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== sv/overwriting_ring_buffer.sv =====
// Overwriting ring buffer top level: stream ports around the controller and the datapath.
//
// A circular buffer of DEPTH words that replaces its oldest word when a push
// arrives while full. A push, a pop or a dump on an empty buffer, and an
// unused mode, are handled in the idle state; a pop of a stored word and a
// dump pass through the streaming state, because the entry memory has a
// registered read port and the first word of a run is read out as
// the word is accepted. Once a dump has started, it delivers one word a cycle
// while the output side takes them, and no new input word is accepted until
// its last word is loaded. The output register lets a new input word be
// accepted in the same cycle as the previous result is taken. The memory is
// not cleared at reset; only entries that were written are ever output.
module overwriting_ring_buffer #(
    parameter int unsigned DEPTH      = orb_pkg::DEPTH_DEFAULT,
    parameter int unsigned DATA_WIDTH = orb_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [orb_pkg::DIN_W-1:0]     s_axis_tdata,  // [31:0] data_in
    input  logic [orb_pkg::MODE_W-1:0]    s_axis_tuser,  // [1:0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [orb_pkg::OTDATA_W-1:0]  m_axis_tdata,  // [31:0] data_out, [36:32] fill_count
    output logic [orb_pkg::OTUSER_W-1:0]  m_axis_tuser,  // [0] valid_res, [1] overwrote
    output logic                          m_axis_tlast
);

    orb_pkg::t_dp_cmd w_cmd;
    orb_pkg::t_dp_sts w_sts;

    logic [orb_pkg::DOUT_W-1:0] w_data_out;
    logic [orb_pkg::FILL_W-1:0] w_fill;
    logic                       w_valid_res;
    logic                       w_overwrote;

    orb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (s_axis_tuser),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    orb_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_data_in    (s_axis_tdata),
        .o_data_out   (w_data_out),
        .o_valid_res  (w_valid_res),
        .o_last       (m_axis_tlast),
        .o_overwrote  (w_overwrote),
        .o_fill_count (w_fill)
    );

    assign m_axis_tdata = {
        {(orb_pkg::OTDATA_W - orb_pkg::DOUT_W - orb_pkg::FILL_W){1'b0}},
        w_fill,
        w_data_out
    };
    assign m_axis_tuser = {w_overwrote, w_valid_res};

`ifndef ASSERT_OFF
    // Only a push result can report an overwrite, and it carries no word.
    a_ovw_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("overwrite flagged on a result that is not a push");

    // A result without a stored word is always a single, zero result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[orb_pkg::DOUT_W-1:0] == '0))
        else $error("result without a stored word is not zero and last");

    // No new word is taken while a dump is still in the middle of its run.
    a_no_accept_mid_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted during a dump");
`endif

endmodule
